[sv/gdr_pkg.sv]
// Shared constants, types and codes for the grid DDA column raycaster.
`default_nettype none
package gdr_pkg;

	// Map geometry
	localparam int MAP_DIM    = 64;
	localparam int MAP_W      = $clog2(MAP_DIM);
	localparam int MX_W       = ((MAP_W > 6) ? MAP_W : 6) + 1;
	localparam int ADDR_W     = 2 * MAP_W;
	localparam int TILE_DEPTH = MAP_DIM * MAP_DIM;
	localparam int STEP_MAX   = 2 * MAP_DIM + 2;
	localparam int STEP_W     = $clog2(STEP_MAX + 1);

	// Screen limits and distance format
	localparam int COLUMN_LIMIT = 1024;
	localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
	localparam logic [31:0] RECIP_ONE = 32'h4000_0000;

	// Register map
	typedef enum logic [2:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_DIR_X   = 3'd2,
		REG_DIR_Y   = 3'd3,
		REG_PLANE_X = 3'd4,
		REG_PLANE_Y = 3'd5,
		REG_NUM_COL = 3'd6,
		REG_ROWS    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] dir_x;
		logic [15:0] dir_y;
		logic [15:0] plane_x;
		logic [15:0] plane_y;
		logic [10:0] num_columns;
		logic [9:0]  screen_rows;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAMX,
		ST_RAYX,
		ST_RAYY,
		ST_DX,
		ST_DY,
		ST_SIDEX,
		ST_SIDEY,
		ST_STEP,
		ST_CHECK,
		ST_HDIV,
		ST_HIT,
		ST_MISS
	} state_t;

	typedef enum logic [1:0] {
		DIV_CAMX,
		DIV_DX,
		DIV_DY,
		DIV_H
	} div_sel_t;

	typedef struct packed {
		logic     clr_step;
		logic     capture;
		logic     div_start;
		logic     ld_div;
		div_sel_t div_sel;
		logic     ld_rdx;
		logic     ld_rdy;
		logic     init_sx;
		logic     init_sy;
		logic     step;
		logic     ld_tile;
		logic     ld_hit;
		logic     ld_miss;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic col_ok;
		logic div_busy;
		logic div_done;
		logic oob;
		logic hit;
		logic steps_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[sv/gdr_if.sv]
// Request channel interfaces: cast/write requests in, column results out.
`default_nettype none
interface gdr_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [9:0] column_index;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [2:0] cell_value;

	modport source (output valid, command, column_index, cell_x, cell_y, cell_value,
		input ready);
	modport sink (input valid, command, column_index, cell_x, cell_y, cell_value,
		output ready);
endinterface

interface gdr_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  stripe_column;
	logic [15:0] wall_height;
	logic [9:0]  draw_top;
	logic [9:0]  draw_bottom;
	logic [1:0]  wall_color;
	logic        wall_side;
	logic [7:0]  shade_alpha;
	logic        wall_found;

	modport source (output valid, stripe_column, wall_height, draw_top, draw_bottom,
		wall_color, wall_side, shade_alpha, wall_found, input ready);
	modport sink (input valid, stripe_column, wall_height, draw_top, draw_bottom,
		wall_color, wall_side, shade_alpha, wall_found, output ready);
endinterface
`default_nettype wire

[sv/gdr_div.sv]
// Radix-2 restoring divider, 32-bit quotient, one bit per cycle.
`default_nettype none
module gdr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic             done,
	output logic [31:0]      quo
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	// Shift in the next dividend bit and try a subtract
	// (a zero divisor yields an all-ones quotient, which saturates downstream)
	always_comb begin
		rem_sh = {rem_q, quo_q[31]};
		diff   = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

[sv/gdr_ctrl.sv]
// Sequencer for map clearing, cell writes and the per-column cast.
`default_nettype none
module gdr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_cast,
	output logic               in_ready,
	input  wire gdr_pkg::sts_t sts,
	output gdr_pkg::cmd_t      cmd
);
	gdr_pkg::state_t st_q;
	gdr_pkg::state_t st_nx;
	logic            accept;
	logic            div_state;

	assign in_ready = (st_q == gdr_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= gdr_pkg::ST_CLEAR;
		else         st_q <= st_nx;
	end

	// Next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			gdr_pkg::ST_CLEAR: if (sts.clr_last) st_nx = gdr_pkg::ST_IDLE;
			gdr_pkg::ST_IDLE:  if (accept && in_cast) st_nx = gdr_pkg::ST_CAMX;
			gdr_pkg::ST_CAMX: begin
				if (!sts.col_ok)      st_nx = gdr_pkg::ST_IDLE;
				else if (sts.div_done) st_nx = gdr_pkg::ST_RAYX;
			end
			gdr_pkg::ST_RAYX:  st_nx = gdr_pkg::ST_RAYY;
			gdr_pkg::ST_RAYY:  st_nx = gdr_pkg::ST_DX;
			gdr_pkg::ST_DX:    if (sts.div_done) st_nx = gdr_pkg::ST_DY;
			gdr_pkg::ST_DY:    if (sts.div_done) st_nx = gdr_pkg::ST_SIDEX;
			gdr_pkg::ST_SIDEX: st_nx = gdr_pkg::ST_SIDEY;
			gdr_pkg::ST_SIDEY: st_nx = gdr_pkg::ST_STEP;
			gdr_pkg::ST_STEP:  st_nx = gdr_pkg::ST_CHECK;
			gdr_pkg::ST_CHECK: begin
				priority if (sts.oob)   st_nx = gdr_pkg::ST_MISS;
				else if (sts.hit)        st_nx = gdr_pkg::ST_HDIV;
				else if (sts.steps_done) st_nx = gdr_pkg::ST_MISS;
				else                     st_nx = gdr_pkg::ST_STEP;
			end
			gdr_pkg::ST_HDIV:  if (sts.div_done) st_nx = gdr_pkg::ST_HIT;
			gdr_pkg::ST_HIT:   if (sts.out_free) st_nx = gdr_pkg::ST_IDLE;
			gdr_pkg::ST_MISS:  if (sts.out_free) st_nx = gdr_pkg::ST_IDLE;
			default:           st_nx = gdr_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		div_state = 1'b0;
		cmd.div_sel = gdr_pkg::DIV_CAMX;
		unique case (st_q)
			gdr_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			gdr_pkg::ST_IDLE:  cmd.capture = accept;
			gdr_pkg::ST_CAMX: begin
				div_state   = sts.col_ok;
				cmd.div_sel = gdr_pkg::DIV_CAMX;
			end
			gdr_pkg::ST_RAYX:  cmd.ld_rdx = 1'b1;
			gdr_pkg::ST_RAYY:  cmd.ld_rdy = 1'b1;
			gdr_pkg::ST_DX: begin
				div_state   = 1'b1;
				cmd.div_sel = gdr_pkg::DIV_DX;
			end
			gdr_pkg::ST_DY: begin
				div_state   = 1'b1;
				cmd.div_sel = gdr_pkg::DIV_DY;
			end
			gdr_pkg::ST_SIDEX: cmd.init_sx = 1'b1;
			gdr_pkg::ST_SIDEY: cmd.init_sy = 1'b1;
			gdr_pkg::ST_STEP:  cmd.step = 1'b1;
			gdr_pkg::ST_CHECK: cmd.ld_tile = 1'b1;
			gdr_pkg::ST_HDIV: begin
				div_state   = 1'b1;
				cmd.div_sel = gdr_pkg::DIV_H;
			end
			gdr_pkg::ST_HIT:   cmd.ld_hit = sts.out_free;
			gdr_pkg::ST_MISS:  cmd.ld_miss = sts.out_free;
			default:           cmd.clr_step = 1'b0;
		endcase
		// launch once on entry, take the quotient on the done pulse
		cmd.div_start = div_state && !sts.div_busy && !sts.div_done;
		cmd.ld_div    = div_state && sts.div_done;
	end
endmodule
`default_nettype wire

[sv/gdr_dpath.sv]
// Datapath: tile memory, ray setup, grid walk, height math and result register.
`default_nettype none
module gdr_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gdr_pkg::cfg_t cfg,
	input  wire gdr_pkg::cmd_t cmd,
	output gdr_pkg::sts_t      sts,
	input  wire logic          in_command,
	input  wire logic [9:0]    in_column_index,
	input  wire logic [5:0]    in_cell_x,
	input  wire logic [5:0]    in_cell_y,
	input  wire logic [2:0]    in_cell_value,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [9:0]         out_stripe_column,
	output logic [15:0]        out_wall_height,
	output logic [9:0]         out_draw_top,
	output logic [9:0]         out_draw_bottom,
	output logic [1:0]         out_wall_color,
	output logic               out_wall_side,
	output logic [7:0]         out_shade_alpha,
	output logic               out_wall_found
);
	// Tile memory and clear sweep
	logic [2:0]                    tile_mem [gdr_pkg::TILE_DEPTH];
	logic [2:0]                    tile_rd_q;
	logic [2:0]                    tile_q;
	logic [gdr_pkg::ADDR_W-1:0]    clr_q;
	logic [gdr_pkg::ADDR_W-1:0]    wr_addr;
	logic [gdr_pkg::ADDR_W-1:0]    rd_addr;
	logic                          wr_ok;

	// Ray setup
	logic [9:0]          col_q;
	logic [10:0]         ncol;
	logic [9:0]          rows;
	logic signed [15:0]  camx_q;
	logic signed [18:0]  rdx_q;
	logic signed [18:0]  rdy_q;
	logic signed [31:0]  ray_prod;
	logic signed [31:0]  ray_bias;
	logic signed [18:0]  ray_sum;
	logic [18:0]         mag_x;
	logic [18:0]         mag_y;
	logic [23:0]         dx_q;
	logic [23:0]         dy_q;
	logic [23:0]         dist_sat;
	logic [15:0]         h_q;

	// Walk state
	logic [31:0]              sx_q;
	logic [31:0]              sy_q;
	logic [gdr_pkg::MX_W-1:0] mx_q;
	logic [gdr_pkg::MX_W-1:0] my_q;
	logic [gdr_pkg::MX_W-1:0] mx_nx;
	logic [gdr_pkg::MX_W-1:0] my_nx;
	logic                     stx_neg_q;
	logic                     sty_neg_q;
	logic                     side_q;
	logic [gdr_pkg::STEP_W-1:0] step_q;
	logic                     adv_x;
	logic [10:0]              frac;
	logic [23:0]              side_d;
	logic [34:0]              side_prod;
	logic [31:0]              perp;

	// Divider
	logic [31:0] div_num;
	logic [31:0] div_den;
	logic [31:0] div_quo;
	logic        div_busy;
	logic        div_done;

	// Result shaping
	logic [8:0]  row_half;
	logic [14:0] h_half;
	logic [9:0]  top_v;
	logic [16:0] bot_sum;
	logic [9:0]  bot_v;
	logic        out_valid_q;

	// Effective column count and screen rows
	always_comb begin
		if (cfg.num_columns == 11'd0) ncol = 11'd1;
		else if (32'(cfg.num_columns) > gdr_pkg::COLUMN_LIMIT)
			ncol = 11'(gdr_pkg::COLUMN_LIMIT);
		else ncol = cfg.num_columns;
		rows = (cfg.screen_rows == 10'd0) ? 10'd1 : cfg.screen_rows;
	end

	// Map write and clear
	assign wr_ok   = cmd.capture && !in_command &&
		(32'(in_cell_x) < gdr_pkg::MAP_DIM) && (32'(in_cell_y) < gdr_pkg::MAP_DIM);
	assign wr_addr = gdr_pkg::ADDR_W'((32'(in_cell_y) << gdr_pkg::MAP_W) | 32'(in_cell_x));

	always_ff @(posedge clk) begin
		if (cmd.clr_step)  tile_mem[clr_q] <= 3'd0;
		else if (wr_ok)    tile_mem[wr_addr] <= in_cell_value;
		tile_rd_q <= tile_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
	end

	// Ray direction: dir + plane*camx/16384, truncated toward zero
	always_comb begin
		ray_prod = (cmd.ld_rdy ? $signed(cfg.plane_y) : $signed(cfg.plane_x)) * camx_q;
		ray_bias = ray_prod + (ray_prod[31] ? 32'sd16383 : 32'sd0);
		ray_sum  = 19'(cmd.ld_rdy ? $signed(cfg.dir_y) : $signed(cfg.dir_x))
			+ 19'(ray_bias >>> 14);
		mag_x = rdx_q[18] ? 19'(-rdx_q) : 19'(rdx_q);
		mag_y = rdy_q[18] ? 19'(-rdy_q) : 19'(rdy_q);
	end

	// Divider operand selection
	always_comb begin
		unique case (cmd.div_sel)
			gdr_pkg::DIV_CAMX: begin
				div_num = 32'({col_q, 15'd0});
				div_den = 32'(ncol);
			end
			gdr_pkg::DIV_DX: begin
				div_num = gdr_pkg::RECIP_ONE;
				div_den = 32'(mag_x);
			end
			gdr_pkg::DIV_DY: begin
				div_num = gdr_pkg::RECIP_ONE;
				div_den = 32'(mag_y);
			end
			gdr_pkg::DIV_H: begin
				div_num = 32'({rows, 16'd0});
				div_den = perp;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
		dist_sat = (|div_quo[31:24]) ? gdr_pkg::DIST_MAX : div_quo[23:0];
	end

	gdr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Starting side distance: fraction to the first boundary times delta
	always_comb begin
		if (cmd.init_sy)
			frac = rdy_q[18] ? {1'b0, cfg.pos_y[9:0]} : 11'd1024 - {1'b0, cfg.pos_y[9:0]};
		else
			frac = rdx_q[18] ? {1'b0, cfg.pos_x[9:0]} : 11'd1024 - {1'b0, cfg.pos_x[9:0]};
		side_d    = cmd.init_sy ? dy_q : dx_q;
		side_prod = 35'(frac) * 35'(side_d);
	end

	// Next cell; the read address follows the axis that advances
	always_comb begin
		adv_x   = sx_q < sy_q;
		mx_nx   = stx_neg_q ? mx_q - 1'b1 : mx_q + 1'b1;
		my_nx   = sty_neg_q ? my_q - 1'b1 : my_q + 1'b1;
		rd_addr = adv_x ? {my_q[gdr_pkg::MAP_W-1:0], mx_nx[gdr_pkg::MAP_W-1:0]}
		                : {my_nx[gdr_pkg::MAP_W-1:0], mx_q[gdr_pkg::MAP_W-1:0]};
		perp    = side_q ? sy_q - 32'(dy_q) : sx_q - 32'(dx_q);
	end

	// Setup and walk registers
	always_ff @(posedge clk) begin
		if (cmd.capture) col_q <= in_column_index;
		if (cmd.ld_div) begin
			unique case (cmd.div_sel)
				gdr_pkg::DIV_CAMX: camx_q <= $signed({1'b0, div_quo[14:0]}) - 16'sd16384;
				gdr_pkg::DIV_DX:   dx_q <= dist_sat;
				gdr_pkg::DIV_DY:   dy_q <= dist_sat;
				gdr_pkg::DIV_H:    h_q <= (|div_quo[31:16]) ? 16'hFFFF : div_quo[15:0];
				default:           h_q <= h_q;
			endcase
		end
		if (cmd.ld_rdx) rdx_q <= ray_sum;
		if (cmd.ld_rdy) rdy_q <= ray_sum;
		if (cmd.init_sx) begin
			sx_q      <= 32'(side_prod >> 10);
			mx_q      <= gdr_pkg::MX_W'(cfg.pos_x[15:10]);
			my_q      <= gdr_pkg::MX_W'(cfg.pos_y[15:10]);
			stx_neg_q <= rdx_q[18];
			sty_neg_q <= rdy_q[18];
			step_q    <= '0;
		end
		if (cmd.init_sy) sy_q <= 32'(side_prod >> 10);
		if (cmd.step) begin
			step_q <= step_q + 1'b1;
			if (adv_x) begin
				sx_q   <= sx_q + 32'(dx_q);
				mx_q   <= mx_nx;
				side_q <= 1'b0;
			end else begin
				sy_q   <= sy_q + 32'(dy_q);
				my_q   <= my_nx;
				side_q <= 1'b1;
			end
		end
		if (cmd.ld_tile) tile_q <= tile_rd_q;
	end

	// Status
	always_comb begin
		sts.clr_last   = &clr_q;
		sts.col_ok     = {1'b0, col_q} < ncol;
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
		sts.oob        = (32'(mx_q) >= gdr_pkg::MAP_DIM) || (32'(my_q) >= gdr_pkg::MAP_DIM);
		sts.hit        = tile_rd_q != 3'd0;
		sts.steps_done = 32'(step_q) >= gdr_pkg::STEP_MAX;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Draw rows from the wall height
	always_comb begin
		row_half = rows[9:1];
		h_half   = h_q[15:1];
		top_v    = ({6'd0, row_half} > h_half) ? 10'({6'd0, row_half} - h_half) : 10'd0;
		bot_sum  = 17'(row_half) + 17'(h_half);
		bot_v    = (bot_sum >= 17'(rows)) ? rows - 10'd1 : bot_sum[9:0];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                       out_valid_q <= 1'b0;
		else if (cmd.ld_hit || cmd.ld_miss) out_valid_q <= 1'b1;
		else if (out_ready)                 out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_hit) begin
			out_stripe_column <= col_q;
			out_wall_height   <= h_q;
			out_draw_top      <= top_v;
			out_draw_bottom   <= bot_v;
			out_wall_color    <= (tile_q[2] || tile_q == 3'd0) ? 2'd0 : tile_q[1:0];
			out_wall_side     <= side_q;
			out_shade_alpha   <= side_q ? 8'd127 : 8'd255;
			out_wall_found    <= 1'b1;
		end else if (cmd.ld_miss) begin
			out_stripe_column <= col_q;
			out_wall_height   <= '0;
			out_draw_top      <= '0;
			out_draw_bottom   <= '0;
			out_wall_color    <= '0;
			out_wall_side     <= 1'b0;
			out_shade_alpha   <= '0;
			out_wall_found    <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[sv/grid_dda_column_raycaster_core.sv]
// Top level: configuration registers, controller, datapath and channel hookup.
//
//  channel | dir | carries
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | request: map cell write or column cast
//  out_ch  | out | one column result per in-range cast
//  APB     | in  | viewer, camera and screen registers (write at access phase)
//
// A cast passes through the shared divider for the column offset and the two
// reciprocals, and for the height when a wall is hit; each grid step then reads
// the tile memory before the hit test.
// After reset the tile memory is cleared one cell per cycle before the first
// request is accepted. A finished result waits in the output register while the
// next request is taken; a stalled output holds the cast.
`default_nettype none
module grid_dda_column_raycaster_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	gdr_in_if.sink           in_ch,
	gdr_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	gdr_pkg::cfg_t     cfg_q;
	gdr_pkg::cmd_t     cmd;
	gdr_pkg::sts_t     sts;
	gdr_pkg::reg_idx_t reg_sel;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = gdr_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x       <= 16'd32768;
			cfg_q.pos_y       <= 16'd32768;
			cfg_q.dir_x       <= 16'hC000;
			cfg_q.dir_y       <= 16'd0;
			cfg_q.plane_x     <= 16'd0;
			cfg_q.plane_y     <= 16'd10813;
			cfg_q.num_columns <= 11'd320;
			cfg_q.screen_rows <= 10'd480;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				gdr_pkg::REG_POS_X:   cfg_q.pos_x       <= pwdata[15:0];
				gdr_pkg::REG_POS_Y:   cfg_q.pos_y       <= pwdata[15:0];
				gdr_pkg::REG_DIR_X:   cfg_q.dir_x       <= pwdata[15:0];
				gdr_pkg::REG_DIR_Y:   cfg_q.dir_y       <= pwdata[15:0];
				gdr_pkg::REG_PLANE_X: cfg_q.plane_x     <= pwdata[15:0];
				gdr_pkg::REG_PLANE_Y: cfg_q.plane_y     <= pwdata[15:0];
				gdr_pkg::REG_NUM_COL: cfg_q.num_columns <= pwdata[10:0];
				gdr_pkg::REG_ROWS:    cfg_q.screen_rows <= pwdata[9:0];
				default:              cfg_q.pos_x       <= cfg_q.pos_x;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_sel)
			gdr_pkg::REG_POS_X:   prdata = 32'(cfg_q.pos_x);
			gdr_pkg::REG_POS_Y:   prdata = 32'(cfg_q.pos_y);
			gdr_pkg::REG_DIR_X:   prdata = 32'(cfg_q.dir_x);
			gdr_pkg::REG_DIR_Y:   prdata = 32'(cfg_q.dir_y);
			gdr_pkg::REG_PLANE_X: prdata = 32'(cfg_q.plane_x);
			gdr_pkg::REG_PLANE_Y: prdata = 32'(cfg_q.plane_y);
			gdr_pkg::REG_NUM_COL: prdata = 32'(cfg_q.num_columns);
			gdr_pkg::REG_ROWS:    prdata = 32'(cfg_q.screen_rows);
			default:              prdata = '0;
		endcase
	end

	gdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_cast (in_ch.command),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gdr_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.sts              (sts),
		.in_command       (in_ch.command),
		.in_column_index  (in_ch.column_index),
		.in_cell_x        (in_ch.cell_x),
		.in_cell_y        (in_ch.cell_y),
		.in_cell_value    (in_ch.cell_value),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_stripe_column(out_ch.stripe_column),
		.out_wall_height  (out_ch.wall_height),
		.out_draw_top     (out_ch.draw_top),
		.out_draw_bottom  (out_ch.draw_bottom),
		.out_wall_color   (out_ch.wall_color),
		.out_wall_side    (out_ch.wall_side),
		.out_shade_alpha  (out_ch.shade_alpha),
		.out_wall_found   (out_ch.wall_found)
	);

`ifndef NO_ASSERTIONS
	// Only one major datapath action per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.step, cmd.div_start, cmd.ld_hit, cmd.ld_miss}))
		else $error("conflicting datapath commands");

	// A result is only loaded when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_hit || cmd.ld_miss) |-> sts.out_free)
		else $error("result loaded over a pending result");

	// A wall hit shows up as a valid result with the found flag set
	a_hit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_hit |=> (out_ch.valid && out_ch.wall_found))
		else $error("hit result not presented");
`endif
endmodule
`default_nettype wire
